// ===== hw/rtl/mtcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Missing-tooth crank decoder package
// Shared widths, constants and the controller/datapath command and status
// structs.
// ----------------------------------------------------------------------------
package mtcd_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TOOTH_W = 8;
  localparam int unsigned RPM_W   = 20;
  localparam int unsigned ANGLE_W = 12;
  localparam int unsigned WIN_W   = 14;

  localparam logic [WIN_W-1:0] TOOTH_TENTHS  = 14'd60;
  localparam logic [RPM_W-1:0] RPM_NUMERATOR = 20'd1000000;

  typedef struct packed {
    logic accept;
    logic sum_step;
    logic load_avg_shift;
    logic div_start_avg;
    logic load_avg_quo;
    logic div_start_rpm;
    logic load_rpm;
    logic load_out;
  } mtcd_cmd_t;

  typedef struct packed {
    logic need_avg;
    logic sum_last;
    logic avg_zero;
    logic div_done;
    logic div_skip;
  } mtcd_sts_t;

endpackage

// ===== hw/rtl/mtcd_if.sv =====
// ----------------------------------------------------------------------------
// Missing-tooth crank decoder channels
// Valid/ready channels for tooth edge timestamps and decoded results.
// ----------------------------------------------------------------------------
interface mtcd_in_if;
  logic                           valid;
  logic                           ready;
  logic [mtcd_pkg::STAMP_W-1:0]   edge_timestamp;

  modport source (output valid, output edge_timestamp, input ready);
  modport sink   (input valid, input edge_timestamp, output ready);
endinterface

interface mtcd_out_if;
  logic                           valid;
  logic                           ready;
  logic [mtcd_pkg::TOOTH_W-1:0]   tooth_position;
  logic                           in_sync;
  logic [mtcd_pkg::RPM_W-1:0]     engine_rpm;
  logic                           spark_request;
  logic [mtcd_pkg::STAMP_W-1:0]   edge_period;

  modport source (output valid, output tooth_position, output in_sync, output engine_rpm,
                  output spark_request, output edge_period, input ready);
  modport sink   (input valid, input tooth_position, input in_sync, input engine_rpm,
                  input spark_request, input edge_period, output ready);
endinterface

// ===== hw/rtl/missing_tooth_crank_decoder.sv =====
// ----------------------------------------------------------------------------
// Missing-tooth crank decoder
// 60-2 trigger wheel decoder: tooth index, gap sync, spark window and
// averaged engine speed per tooth edge.
//
//   channel   dir  payload                                          transfer
//   in_i      in   edge_timestamp                                   valid & ready
//   out_o     out  tooth_position in_sync engine_rpm spark_request  valid & ready
//                  edge_period
//   spark_angle_*  in  12-bit register write                        we high
//
// An edge with nothing to average (first edges, gap, zero period) goes straight
// to the result write; one with a zero average sums and averages the history;
// one updating the speed also runs the speed division; a HISTORY_DEPTH not a
// power of two adds a divider pass for the average. One edge in work at a time;
// the next is taken while a result waits, but the result register loads only
// once that result is taken. Reset clears the angle, edge and speed state only.
// ----------------------------------------------------------------------------
module missing_tooth_crank_decoder #(
  parameter int unsigned TEETH_BEFORE_GAP = 58,
  parameter int unsigned HISTORY_DEPTH    = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          spark_angle_we_i,
  input  logic [mtcd_pkg::ANGLE_W-1:0]  spark_angle_i,
  mtcd_in_if.sink                       in_i,
  mtcd_out_if.source                    out_o
);

  mtcd_pkg::mtcd_cmd_t cmd;
  mtcd_pkg::mtcd_sts_t sts;

  mtcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mtcd_dp #(
    .TEETH_BEFORE_GAP (TEETH_BEFORE_GAP),
    .HISTORY_DEPTH    (HISTORY_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (spark_angle_we_i),
    .cfg_angle_i      (spark_angle_i),
    .stamp_i          (in_i.edge_timestamp),
    .tooth_position_o (out_o.tooth_position),
    .in_sync_o        (out_o.in_sync),
    .engine_rpm_o     (out_o.engine_rpm),
    .spark_request_o  (out_o.spark_request),
    .edge_period_o    (out_o.edge_period)
  );

`ifndef SYNTHESIS
  a_one_edge_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second edge taken while one is in work");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_o.valid || out_o.ready))
    else $error("result register loaded while holding an untaken result");

  a_div_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_done |-> !in_i.ready)
    else $error("divider finished while controller idle");
`endif

endmodule

// ===== hw/rtl/mtcd_div.sv =====
// ----------------------------------------------------------------------------
// Missing-tooth crank decoder divider
// Restoring divider, one quotient bit per cycle, MSB-aligned dividend.
// ----------------------------------------------------------------------------
module mtcd_div #(
  parameter int unsigned DVD_W = 34,
  parameter int unsigned DVS_W = 32,
  parameter int unsigned CNT_W = $clog2(DVD_W + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  input  logic [CNT_W-1:0] steps_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W-1:0] quo_q;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      dvd_q <= dividend_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/mtcd_dp.sv =====
// ----------------------------------------------------------------------------
// Missing-tooth crank decoder datapath
// Period, gap detection, tooth index, spark window, period history, speed
// divider and result register.
// ----------------------------------------------------------------------------
module mtcd_dp #(
  parameter int unsigned TEETH_BEFORE_GAP = 58,
  parameter int unsigned HISTORY_DEPTH    = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtcd_pkg::mtcd_cmd_t            cmd_i,
  output mtcd_pkg::mtcd_sts_t            sts_o,
  input  logic                           cfg_we_i,
  input  logic [mtcd_pkg::ANGLE_W-1:0]   cfg_angle_i,
  input  logic [mtcd_pkg::STAMP_W-1:0]   stamp_i,
  output logic [mtcd_pkg::TOOTH_W-1:0]   tooth_position_o,
  output logic                           in_sync_o,
  output logic [mtcd_pkg::RPM_W-1:0]     engine_rpm_o,
  output logic                           spark_request_o,
  output logic [mtcd_pkg::STAMP_W-1:0]   edge_period_o
);

  localparam int unsigned STAMP_W  = mtcd_pkg::STAMP_W;
  localparam int unsigned TOOTH_W  = mtcd_pkg::TOOTH_W;
  localparam int unsigned RPM_W    = mtcd_pkg::RPM_W;
  localparam int unsigned WIN_W    = mtcd_pkg::WIN_W;
  localparam int unsigned LOG_D    = $clog2(HISTORY_DEPTH);
  localparam int unsigned SUM_W    = STAMP_W + LOG_D;
  localparam int unsigned CNT_W    = $clog2(SUM_W + 1);
  localparam bit          DIV_SKIP = ((1 << LOG_D) == HISTORY_DEPTH);

  localparam logic [SUM_W-1:0]   RPM_ALIGNED = {mtcd_pkg::RPM_NUMERATOR,
                                                {(SUM_W - RPM_W){1'b0}}};
  localparam logic [STAMP_W-1:0] DEPTH_DVS   = STAMP_W'(HISTORY_DEPTH);

  logic [mtcd_pkg::ANGLE_W-1:0] angle_q;
  logic [STAMP_W-1:0]           last_stamp_q;
  logic [STAMP_W-1:0]           prev_period_q;
  logic [TOOTH_W-1:0]           tooth_q;
  logic                         sync_q;
  logic                         spark_q;
  logic [RPM_W-1:0]             rpm_q;
  logic [STAMP_W-1:0]           hist_q [HISTORY_DEPTH];
  logic [STAMP_W-1:0]           dropped_q;
  logic [SUM_W-1:0]             acc_q;
  logic [LOG_D-1:0]             idx_q;
  logic [STAMP_W-1:0]           avg_q;

  logic [STAMP_W-1:0]           period;
  logic [STAMP_W:0]             limit;
  logic                         have_prev;
  logic                         gap;
  logic                         need_avg;
  logic [STAMP_W-1:0]           h0_new;
  logic [WIN_W-1:0]             win_lo;
  logic [WIN_W-1:0]             win_hi;
  logic [WIN_W-1:0]             angle_ext;
  logic                         spark;
  logic [STAMP_W-1:0]           term;

  logic                         div_start;
  logic [SUM_W-1:0]             div_dividend;
  logic [STAMP_W-1:0]           div_divisor;
  logic [CNT_W-1:0]             div_steps;
  logic                         div_done;
  logic [SUM_W-1:0]             div_quo;

  assign period    = stamp_i - last_stamp_q;
  assign limit     = {1'b0, prev_period_q} + {2'b00, prev_period_q[STAMP_W-1:1]};
  assign have_prev = prev_period_q != '0;
  assign gap       = have_prev && ({1'b0, period} > limit);
  assign need_avg  = have_prev && !gap && (period != '0);
  assign h0_new    = need_avg ? period : hist_q[0];

  assign win_lo    = WIN_W'(tooth_q) * mtcd_pkg::TOOTH_TENTHS;
  assign win_hi    = win_lo + mtcd_pkg::TOOTH_TENTHS;
  assign angle_ext = WIN_W'(angle_q);
  assign spark     = (angle_ext >= win_lo) && (angle_ext < win_hi);

  // history sum = hist[1..D-1] after the shift plus the entry shifted out
  assign term = (idx_q == '0) ? dropped_q : hist_q[idx_q];

  assign div_start    = cmd_i.div_start_avg | cmd_i.div_start_rpm;
  assign div_dividend = cmd_i.div_start_rpm ? RPM_ALIGNED : acc_q;
  assign div_divisor  = cmd_i.div_start_rpm ? avg_q : DEPTH_DVS;
  assign div_steps    = cmd_i.div_start_rpm ? CNT_W'(RPM_W) : CNT_W'(SUM_W);

  mtcd_div #(
    .DVD_W (SUM_W),
    .DVS_W (STAMP_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    sts_o          = '0;
    sts_o.need_avg = need_avg;
    sts_o.sum_last = idx_q == LOG_D'(HISTORY_DEPTH - 1);
    sts_o.avg_zero = avg_q == '0;
    sts_o.div_done = div_done;
    sts_o.div_skip = DIV_SKIP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q       <= '0;
      last_stamp_q  <= '0;
      prev_period_q <= '0;
      tooth_q       <= '0;
      sync_q        <= 1'b0;
      spark_q       <= 1'b0;
      rpm_q         <= '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        angle_q <= cfg_angle_i;
      end
      if (cmd_i.accept) begin
        last_stamp_q  <= stamp_i;
        prev_period_q <= period;
        spark_q       <= spark;
        if (have_prev) begin
          if (gap) begin
            sync_q  <= tooth_q == TOOTH_W'(TEETH_BEFORE_GAP);
            tooth_q <= '0;
          end else begin
            tooth_q <= tooth_q + 1'b1;
          end
        end
        hist_q[0] <= h0_new;
        hist_q[1] <= h0_new;
        for (int k = 2; k < HISTORY_DEPTH; k++) begin
          hist_q[k] <= hist_q[k-1];
        end
      end
      if (cmd_i.load_rpm) begin
        rpm_q <= div_quo[RPM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dropped_q <= hist_q[HISTORY_DEPTH-1];
      acc_q     <= '0;
      idx_q     <= '0;
    end else if (cmd_i.sum_step) begin
      acc_q <= acc_q + SUM_W'(term);
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.load_avg_shift) begin
      avg_q <= STAMP_W'(acc_q >> LOG_D);
    end else if (cmd_i.load_avg_quo) begin
      avg_q <= div_quo[STAMP_W-1:0];
    end
    if (cmd_i.load_out) begin
      tooth_position_o <= tooth_q;
      in_sync_o        <= sync_q;
      engine_rpm_o     <= rpm_q;
      spark_request_o  <= spark_q;
      edge_period_o    <= prev_period_q;
    end
  end

endmodule

// ===== hw/rtl/mtcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Missing-tooth crank decoder controller
// Sequences edge intake, history sum, average and speed divisions, and the
// result register handoff.
// ----------------------------------------------------------------------------
module mtcd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mtcd_pkg::mtcd_sts_t sts_i,
  output mtcd_pkg::mtcd_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SUM     = 3'd1;
  localparam logic [2:0] S_AVG     = 3'd2;
  localparam logic [2:0] S_DIV_AVG = 3'd3;
  localparam logic [2:0] S_RPM     = 3'd4;
  localparam logic [2:0] S_DIV_RPM = 3'd5;
  localparam logic [2:0] S_WRITE   = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.need_avg ? S_SUM : S_WRITE;
        end
      end
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.sum_last) begin
          state_d = S_AVG;
        end
      end
      S_AVG: begin
        if (sts_i.div_skip) begin
          cmd_o.load_avg_shift = 1'b1;
          state_d              = S_RPM;
        end else begin
          cmd_o.div_start_avg = 1'b1;
          state_d             = S_DIV_AVG;
        end
      end
      S_DIV_AVG: begin
        if (sts_i.div_done) begin
          cmd_o.load_avg_quo = 1'b1;
          state_d            = S_RPM;
        end
      end
      S_RPM: begin
        if (sts_i.avg_zero) begin
          state_d = S_WRITE;
        end else begin
          cmd_o.div_start_rpm = 1'b1;
          state_d             = S_DIV_RPM;
        end
      end
      S_DIV_RPM: begin
        if (sts_i.div_done) begin
          cmd_o.load_rpm = 1'b1;
          state_d        = S_WRITE;
        end
      end
      S_WRITE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
